// File: hdl/htwd_pkg.sv
// Shared types and constants for the Huffman tree-walk decoder.
`timescale 1ns / 1ps
package htwd_pkg;

   localparam int unsigned NODE_W  = 9;
   localparam int unsigned SYM_W   = 8;
   localparam int unsigned DATA_W  = 8;
   localparam int unsigned COUNT_W = 4;

   localparam logic ACTION_LOAD   = 1'b0;
   localparam logic ACTION_DECODE = 1'b1;

   typedef struct packed {
      logic                 action;
      logic [7:0]           node_index;
      logic [NODE_W-1:0]    left_child;
      logic [NODE_W-1:0]    right_child;
      logic [DATA_W-1:0]    data_byte;
      logic [COUNT_W-1:0]   bit_count;
      logic                 restart_walk;
   } req_type;

   typedef struct packed {
      logic [SYM_W-1:0] symbol;
      logic             last_of_run;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_WALK  = 3'b010,
      ST_FLUSH = 3'b100
   } state_type;

endpackage

// File: hdl/huffman_tree_walk_decoder.sv
// Top level of the bit-serial Huffman tree-walk decoder.
// A load item (action 0) writes the two children of one internal node into
// the child table; an index beyond the table is dropped. A decode item
// (action 1) walks one compressed bit per cycle unless stalled, most
// significant valid bit first, through at most 8 valid bits, then, when it
// produced a symbol, releases its last symbol with last_of_run set. The
// walk rate is set by the child table's registered read port: each bit
// needs the node found by the previous bit. A new symbol that finds the
// previous result still waiting on rsp_ready stalls the walk. The walk
// position persists between decode items; restart_walk returns it to the
// root first. The child table has no reset: decode only after the nodes
// reached have been loaded.
`timescale 1ns / 1ps
module huffman_tree_walk_decoder #(
   parameter int unsigned SYMBOL_COUNT = 256
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  htwd_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output htwd_pkg::rsp_type rsp_payload
);

   localparam int unsigned SlotCount = SYMBOL_COUNT - 1;
   localparam int unsigned SlotW     = (SYMBOL_COUNT > 2) ? $clog2(SlotCount) : 1;
   localparam logic [htwd_pkg::NODE_W-1:0] SymLimit  = htwd_pkg::NODE_W'(SYMBOL_COUNT);
   localparam logic [htwd_pkg::NODE_W-1:0] RootNode  = htwd_pkg::NODE_W'(2 * SYMBOL_COUNT - 2);
   localparam logic [htwd_pkg::NODE_W-1:0] SlotLimit = htwd_pkg::NODE_W'(SlotCount);
   localparam logic [htwd_pkg::COUNT_W-1:0] MaxBits  = htwd_pkg::COUNT_W'(htwd_pkg::DATA_W);
   localparam logic [htwd_pkg::COUNT_W-1:0] OneBit   = htwd_pkg::COUNT_W'(1);

   // child table: {right, left} per internal node
   logic [2*htwd_pkg::NODE_W-1:0] table_mem [SlotCount];
   logic [2*htwd_pkg::NODE_W-1:0] rd_data_ff;
   logic [SlotW-1:0]              rd_addr;
   logic                          rd_en;
   logic                          wr_en;

   htwd_pkg::state_type state_ff, state_in;
   logic [htwd_pkg::NODE_W-1:0]  walk_ff, walk_in;
   logic [htwd_pkg::DATA_W-1:0]  shift_ff, shift_in;
   logic [htwd_pkg::COUNT_W-1:0] cnt_ff, cnt_in;
   logic                         pend_valid_ff, pend_valid_in;
   logic [htwd_pkg::SYM_W-1:0]   pend_sym_ff, pend_sym_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   htwd_pkg::rsp_type            rsp_ff, rsp_in;

   logic                         accept;
   logic                         is_decode;
   logic [htwd_pkg::COUNT_W-1:0] req_bits;
   logic [htwd_pkg::NODE_W-1:0]  start_node;
   logic [htwd_pkg::NODE_W-1:0]  child;
   logic [htwd_pkg::NODE_W-1:0]  walk_next;
   logic [htwd_pkg::NODE_W-1:0]  read_node;
   logic [htwd_pkg::NODE_W-1:0]  slot_diff;
   logic                         is_leaf;
   logic                         out_full;
   logic                         stall;
   logic                         push_mid;
   logic                         push_last;

   assign req_ready = (state_ff == htwd_pkg::ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign is_decode = (req_payload.action == htwd_pkg::ACTION_DECODE);
   assign req_bits  = (req_payload.bit_count > MaxBits) ? MaxBits : req_payload.bit_count;
   assign start_node = req_payload.restart_walk ? RootNode : walk_ff;

   // current bit picks a child of the node in the registered read data
   assign child   = shift_ff[htwd_pkg::DATA_W-1]
                  ? rd_data_ff[2*htwd_pkg::NODE_W-1:htwd_pkg::NODE_W]
                  : rd_data_ff[htwd_pkg::NODE_W-1:0];
   assign is_leaf = (child < SymLimit);
   // a leaf or an out-of-range child sends the walk back to the root
   assign walk_next = (is_leaf || child > RootNode) ? RootNode : child;

   assign out_full = rsp_valid_ff && !rsp_ready;
   assign stall    = (state_ff == htwd_pkg::ST_WALK) && is_leaf && pend_valid_ff && out_full;
   assign push_mid  = (state_ff == htwd_pkg::ST_WALK) && is_leaf && pend_valid_ff && !out_full;
   assign push_last = (state_ff == htwd_pkg::ST_FLUSH) && !out_full;

   // read port address: start node while idle, next node while walking
   assign read_node = (state_ff == htwd_pkg::ST_IDLE) ? start_node : walk_next;
   assign slot_diff = read_node - SymLimit;
   assign rd_addr   = slot_diff[SlotW-1:0];
   assign rd_en     = (state_ff == htwd_pkg::ST_IDLE) || (state_ff == htwd_pkg::ST_WALK && !stall);
   assign wr_en     = accept && !is_decode && ({1'b0, req_payload.node_index} < SlotLimit);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_mem[req_payload.node_index[SlotW-1:0]] <=
            {req_payload.right_child, req_payload.left_child};
      end
      if (rd_en) begin
         rd_data_ff <= table_mem[rd_addr];
      end
   end

   always_comb begin
      state_in      = state_ff;
      walk_in       = walk_ff;
      shift_in      = shift_ff;
      cnt_in        = cnt_ff;
      pend_valid_in = pend_valid_ff;
      pend_sym_in   = pend_sym_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;

      case (state_ff)
         htwd_pkg::ST_IDLE: begin
            if (accept && is_decode) begin
               walk_in  = start_node;
               // left-align the valid bits so the MSB is always the next bit
               shift_in = req_payload.data_byte << (MaxBits - req_bits);
               cnt_in   = req_bits;
               if (req_bits != '0) begin
                  state_in = htwd_pkg::ST_WALK;
               end
            end
         end
         htwd_pkg::ST_WALK: begin
            if (!stall) begin
               walk_in  = walk_next;
               shift_in = shift_ff << 1;
               cnt_in   = cnt_ff - 1'b1;
               if (is_leaf) begin
                  // hold the newest symbol until we know whether it is the last
                  pend_valid_in = 1'b1;
                  pend_sym_in   = child[htwd_pkg::SYM_W-1:0];
               end
               if (push_mid) begin
                  rsp_in.symbol      = pend_sym_ff;
                  rsp_in.last_of_run = 1'b0;
                  rsp_valid_in       = 1'b1;
               end
               if (cnt_ff == OneBit) begin
                  state_in = (is_leaf || pend_valid_ff) ? htwd_pkg::ST_FLUSH
                                                        : htwd_pkg::ST_IDLE;
               end
            end
         end
         htwd_pkg::ST_FLUSH: begin
            if (push_last) begin
               rsp_in.symbol      = pend_sym_ff;
               rsp_in.last_of_run = 1'b1;
               rsp_valid_in       = 1'b1;
               pend_valid_in      = 1'b0;
               state_in           = htwd_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = htwd_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= htwd_pkg::ST_IDLE;
         walk_ff       <= RootNode;
         cnt_ff        <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         walk_ff       <= walk_in;
         cnt_ff        <= cnt_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      shift_ff    <= shift_in;
      pend_sym_ff <= pend_sym_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // walk pointer always names an internal node
   a_walk_internal: assert property (@(posedge clock) disable iff (reset)
      walk_ff >= SymLimit && walk_ff <= RootNode)
      else $error("walk pointer left the internal node range");

   // flushing requires a held symbol
   a_flush_pending: assert property (@(posedge clock) disable iff (reset)
      state_ff == htwd_pkg::ST_FLUSH |-> pend_valid_ff)
      else $error("flush without a held symbol");

   // walking always has bits left
   a_walk_bits: assert property (@(posedge clock) disable iff (reset)
      state_ff == htwd_pkg::ST_WALK |-> cnt_ff != '0)
      else $error("walk with no bits left");

   // a blocked symbol freezes the walk
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      stall |=> state_ff == htwd_pkg::ST_WALK && $stable(cnt_ff) && $stable(walk_ff))
      else $error("walk advanced while its symbol was blocked");

endmodule
